[hdl/comment_blank_line_stripper_unit_defines.svh]
// Assertion macros shared by the checker of the comment and blank line stripper.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef COMMENT_BLANK_LINE_STRIPPER_UNIT_DEFINES_SVH
`define COMMENT_BLANK_LINE_STRIPPER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CBLS_ASSERT_SAME(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("cbls same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CBLS_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("cbls next-cycle check failed");

`endif

[hdl/cbls_pkg.sv]
package cbls_pkg;

	localparam logic [7:0] NEWLINE = 8'd10;
	localparam logic [7:0] HASH    = 8'h23;
	localparam logic [7:0] SPACE   = 8'd32;

	// One input item.
	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_data;
	} in_t;

	// One result item.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic       ws_overflow;
	} out_t;

	// Whitespace is space and the control bytes 9 through 13.
	function automatic logic is_ws(input logic [7:0] b);
		return (b == SPACE) || ((b >= 8'd9) && (b <= 8'd13));
	endfunction

	// Compact 3-bit code of a whitespace byte: 0 for space, 1..5 for 9..13.
	function automatic logic [2:0] ws_code(input logic [7:0] b);
		logic [7:0] diff;
		diff = b - 8'd8;
		return (b == SPACE) ? 3'd0 : diff[2:0];
	endfunction

	function automatic logic [7:0] ws_byte(input logic [2:0] code);
		return (code == 3'd0) ? SPACE : ({5'd0, code} + 8'd8);
	endfunction

endpackage

[hdl/cbls_ram.sv]
module cbls_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hdl/comment_blank_line_stripper_unit.sv]
// Channel | Direction | Payload             | Handshake
// in      | input     | cbls_pkg::in_t      | in_valid / in_ready
// out     | output    | cbls_pkg::out_t     | out_valid / out_ready
//
// An item is accepted while the sequencer is idle. Each result it causes then
// passes through the single output register, and the block takes no new item
// until its last result is loaded; a flush of n pending whitespace bytes reads
// them from the store one per cycle while the output register can take them.
// An item that causes no result frees the block in the next cycle.
// Reset (arst_n low) clears the sequencer, the output register and line state.
// A result that waits on a low out_ready holds its value and pauses the sequencer.
module comment_blank_line_stripper_unit #(
	parameter int PENDING_DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  cbls_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output cbls_pkg::out_t out_data
);

	import cbls_pkg::*;

	localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int CNT_W = $clog2(PENDING_DEPTH + 1);

	// Line phase: leading whitespace, content, or a comment line.
	typedef enum logic [1:0] {
		PH_LEAD,
		PH_BODY,
		PH_COMMENT
	} phase_t;

	// Sequencer: waiting for an item, flushing pending whitespace, sending the
	// item's own byte, sending the newline that closes a line.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FLUSH,
		ST_BYTE,
		ST_NL
	} state_t;

	state_t           state_q;
	phase_t           phase_q, phase_d;
	logic             has_q, has_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             ovf_q, ovf_d;

	logic             go_flush, go_byte, go_nl, ovf_nl, store_ws;
	logic             in_fire, load_ok, out_load;

	// Work latched for the item in progress.
	logic [7:0]       byte_q;
	logic             nl_q;
	logic             ovf_nl_q;
	logic             emit_ovf_q;
	logic [CNT_W-1:0] flush_n_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic [CNT_W-1:0] rd_idx_inc;

	logic             out_valid_q;
	out_t             out_q;

	logic             ram_rd_en;
	logic [IDX_W-1:0] ram_rd_addr;
	logic [2:0]       ram_rd_data;

	assign in_ready   = (state_q == ST_IDLE);
	assign in_fire    = in_valid && in_ready;
	// The output register can take a new result when it is empty or being drained.
	assign load_ok    = !out_valid_q || out_ready;
	// Every busy state puts one result into the output register when it can.
	assign out_load   = (state_q != ST_IDLE) && load_ok;
	assign rd_idx_inc = rd_idx_q + 1'b1;

	// Line bookkeeping for the presented byte. Everything an item does to the
	// line state is decided here in the accept cycle; the sequencer afterwards
	// only replays the results that were planned.
	always_comb begin
		phase_d  = phase_q;
		has_d    = has_q;
		cnt_d    = cnt_q;
		ovf_d    = ovf_q;
		go_flush = 1'b0;
		go_byte  = 1'b0;
		go_nl    = 1'b0;
		ovf_nl   = ovf_q;
		store_ws = 1'b0;
		if (in_data.in_byte == NEWLINE) begin
			// A line that held any byte and was not a comment ends in a newline.
			go_nl   = has_q && (phase_q != PH_COMMENT);
			phase_d = PH_LEAD;
			has_d   = 1'b0;
			cnt_d   = '0;
			ovf_d   = 1'b0;
		end else begin
			has_d = 1'b1;
			unique case (phase_q)
				PH_LEAD: begin
					if (in_data.in_byte == HASH) begin
						phase_d = PH_COMMENT;
					end else if (!is_ws(in_data.in_byte)) begin
						phase_d = PH_BODY;
						go_byte = 1'b1;
					end
				end
				PH_BODY: begin
					if (is_ws(in_data.in_byte)) begin
						// Inner whitespace waits until a visible byte follows.
						if (cnt_q < CNT_W'(PENDING_DEPTH)) begin
							store_ws = 1'b1;
							cnt_d    = cnt_q + 1'b1;
						end else begin
							ovf_d = 1'b1;
						end
					end else begin
						go_flush = (cnt_q != '0);
						go_byte  = 1'b1;
						cnt_d    = '0;
					end
				end
				PH_COMMENT: begin
				end
				default: begin
					phase_d = PH_LEAD;
				end
			endcase
			// The last byte of the text closes the line as a newline would.
			if (in_data.end_of_data) begin
				go_nl   = (phase_d != PH_COMMENT);
				ovf_nl  = ovf_d;
				phase_d = PH_LEAD;
				has_d   = 1'b0;
				cnt_d   = '0;
				ovf_d   = 1'b0;
			end
		end
	end

	// The pending store is read one entry ahead: entry 0 is fetched in the accept
	// cycle, and each flushed entry fetches the next one.
	assign ram_rd_en   = in_fire || ((state_q == ST_FLUSH) && load_ok);
	assign ram_rd_addr = in_fire ? '0 : rd_idx_inc[IDX_W-1:0];

	cbls_ram #(
		.WIDTH (3),
		.DEPTH (PENDING_DEPTH)
	) u_pending_store (
		.clk     (clk),
		.wr_en   (in_fire && store_ws),
		.wr_addr (cnt_q[IDX_W-1:0]),
		.wr_data (ws_code(in_data.in_byte)),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			phase_q     <= PH_LEAD;
			has_q       <= 1'b0;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			byte_q      <= '0;
			nl_q        <= 1'b0;
			ovf_nl_q    <= 1'b0;
			emit_ovf_q  <= 1'b0;
			flush_n_q   <= '0;
			rd_idx_q    <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						phase_q    <= phase_d;
						has_q      <= has_d;
						cnt_q      <= cnt_d;
						ovf_q      <= ovf_d;
						byte_q     <= in_data.in_byte;
						nl_q       <= go_nl;
						ovf_nl_q   <= ovf_nl;
						// Flushed and visible bytes show the flag as it stood before.
						emit_ovf_q <= ovf_q;
						flush_n_q  <= cnt_q;
						rd_idx_q   <= '0;
						if (go_flush) begin
							state_q <= ST_FLUSH;
						end else if (go_byte) begin
							state_q <= ST_BYTE;
						end else if (go_nl) begin
							state_q <= ST_NL;
						end
					end
				end
				ST_FLUSH: begin
					if (load_ok) begin
						out_q.out_byte    <= ws_byte(ram_rd_data);
						out_q.out_last    <= 1'b0;
						out_q.ws_overflow <= emit_ovf_q;
						rd_idx_q          <= rd_idx_inc;
						if (rd_idx_inc == flush_n_q) begin
							state_q <= ST_BYTE;
						end
					end
				end
				ST_BYTE: begin
					if (load_ok) begin
						out_q.out_byte    <= byte_q;
						out_q.out_last    <= !nl_q;
						out_q.ws_overflow <= emit_ovf_q;
						state_q           <= nl_q ? ST_NL : ST_IDLE;
					end
				end
				ST_NL: begin
					if (load_ok) begin
						out_q.out_byte    <= NEWLINE;
						out_q.out_last    <= 1'b1;
						out_q.ws_overflow <= ovf_nl_q;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[hdl/cbls_checker.sv]
`include "comment_blank_line_stripper_unit_defines.svh"

module cbls_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input cbls_pkg::in_t  in_data,
	input logic           out_valid,
	input logic           out_ready,
	input cbls_pkg::out_t out_data
);

	import cbls_pkg::*;

	logic out_nl;
	logic out_blank;

	assign out_nl    = out_valid && (out_data.out_byte == NEWLINE);
	assign out_blank = out_valid && is_ws(out_data.out_byte)
		&& (out_data.out_byte != NEWLINE);

	// A stalled result keeps its value until it is taken.
	`CBLS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

	// An offered item keeps its value until it is taken.
	`CBLS_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data))

	// While an item still has results to send, no new item is taken.
	`CBLS_ASSERT_SAME(a_busy_mid_item, out_valid && !out_data.out_last, !in_ready)

	// A newline always closes the results of its item.
	`CBLS_ASSERT_SAME(a_newline_last, out_nl, out_data.out_last)

	// Flushed whitespace is never the last result of its item; the visible byte that released it follows.
	`CBLS_ASSERT_SAME(a_space_not_last, out_blank, !out_data.out_last)

endmodule

bind comment_blank_line_stripper_unit cbls_checker u_cbls_checker (.*);

[bench/tb_comment_blank_line_stripper_unit.sv]
module tb_comment_blank_line_stripper_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import cbls_pkg::*;

	// The block is built with its default depth of the pending whitespace store.
	localparam int DEPTH = 16;

	// Whitespace bytes other than space. Byte 10 is always handled as a
	// newline, so it never reaches the pending store.
	localparam logic [7:0] TAB  = 8'd9;
	localparam logic [7:0] VTAB = 8'd11;
	localparam logic [7:0] FEED = 8'd12;
	localparam logic [7:0] CRET = 8'd13;

	// Random items after the directed rows, so that the whole run stays near a
	// hundred items.
	localparam int RANDOM_ITEMS = 70;
	// Cycles to keep watching once nothing is expected any more. An item keeps
	// the block busy only while its results are sent, plus any stall.
	localparam int TAIL_CYCLES  = 40;
	// Cycles without any handshake before the run is declared hung. The slowest
	// correct run stalls for at most one sender gap or one receiver stall of the
	// longest length that pick_wait gives, plus the work of the block itself.
	localparam int HANG_LIMIT   = 500;

	// A row of the directed table either carries its results typed in by hand
	// (up to two of them) or leaves them to the line predictor.
	localparam logic TYPED     = 1'b1;
	localparam logic PREDICTED = 1'b0;
	localparam out_t NO_RESULT = '0;

	typedef struct packed {
		logic [7:0] b;
		logic       eod;
		logic       typed;
		logic [1:0] n;
		out_t       r0;
		out_t       r1;
	} row_t;

	// Phases of a line as the predictor tracks them.
	typedef enum logic [1:0] {
		PH_LEAD,
		PH_BODY,
		PH_COMMENT
	} line_phase_e;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	logic in_ready;
	in_t  in_data   = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	// Predictor state: the line phase, whether the line holds any byte yet, the
	// whitespace held back inside the line, and the dropped-whitespace flag.
	line_phase_e phase         = PH_LEAD;
	logic        line_seen     = 1'b0;
	logic [2:0]  blank_codes [DEPTH];
	logic [4:0]  blank_count   = '0;
	logic        blank_dropped = 1'b0;

	out_t step_out [$];     // results of the item just predicted
	out_t cleaned_due [$];  // results still to come from the block, oldest first
	int   mismatches = 0;
	int   in_calm    = 0;
	int   out_calm   = 0;

	// Directed items. The first rows follow reset, then come the byte extremes,
	// inner whitespace that is flushed or trimmed, empty, comment and
	// whitespace-only lines, and end of data on each kind of line.
	row_t plan [24] = '{
		{"A",     1'b0, TYPED,     2'd1, {8'h41, 1'b1, 1'b0}, NO_RESULT},
		{8'h00,   1'b0, TYPED,     2'd1, {8'h00, 1'b1, 1'b0}, NO_RESULT},
		{8'hFF,   1'b0, TYPED,     2'd1, {8'hFF, 1'b1, 1'b0}, NO_RESULT},
		{SPACE,   1'b0, TYPED,     2'd0, NO_RESULT, NO_RESULT},
		{TAB,     1'b0, TYPED,     2'd0, NO_RESULT, NO_RESULT},
		{CRET,    1'b0, TYPED,     2'd0, NO_RESULT, NO_RESULT},
		{"b",     1'b0, PREDICTED, 2'd0, NO_RESULT, NO_RESULT},
		{VTAB,    1'b0, TYPED,     2'd0, NO_RESULT, NO_RESULT},
		{NEWLINE, 1'b0, TYPED,     2'd1, {NEWLINE, 1'b1, 1'b0}, NO_RESULT},
		{NEWLINE, 1'b0, TYPED,     2'd0, NO_RESULT, NO_RESULT},
		{SPACE,   1'b0, TYPED,     2'd0, NO_RESULT, NO_RESULT},
		{HASH,    1'b0, TYPED,     2'd0, NO_RESULT, NO_RESULT},
		{"x",     1'b0, TYPED,     2'd0, NO_RESULT, NO_RESULT},
		{NEWLINE, 1'b0, TYPED,     2'd0, NO_RESULT, NO_RESULT},
		{SPACE,   1'b0, TYPED,     2'd0, NO_RESULT, NO_RESULT},
		{FEED,    1'b0, TYPED,     2'd0, NO_RESULT, NO_RESULT},
		{NEWLINE, 1'b0, TYPED,     2'd1, {NEWLINE, 1'b1, 1'b0}, NO_RESULT},
		{HASH,    1'b1, TYPED,     2'd0, NO_RESULT, NO_RESULT},
		{"z",     1'b1, TYPED,     2'd2, {8'h7A, 1'b0, 1'b0}, {NEWLINE, 1'b1, 1'b0}},
		{NEWLINE, 1'b1, TYPED,     2'd0, NO_RESULT, NO_RESULT},
		{SPACE,   1'b1, TYPED,     2'd1, {NEWLINE, 1'b1, 1'b0}, NO_RESULT},
		{"q",     1'b0, PREDICTED, 2'd0, NO_RESULT, NO_RESULT},
		{SPACE,   1'b0, PREDICTED, 2'd0, NO_RESULT, NO_RESULT},
		{8'h80,   1'b1, PREDICTED, 2'd0, NO_RESULT, NO_RESULT}
	};

	comment_blank_line_stripper_unit #(
		.PENDING_DEPTH(DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always #6 clk = ~clk;

	function automatic logic blank_char(logic [7:0] c);
		return (c == SPACE) || ((c >= TAB) && (c <= CRET));
	endfunction

	function automatic void push_out(logic [7:0] b);
		out_t r;
		r.out_byte    = b;
		r.out_last    = 1'b0;
		r.ws_overflow = blank_dropped;
		step_out.push_back(r);
	endfunction

	// A line ends: anything but an empty or comment line gets its newline,
	// and held-back trailing whitespace is simply forgotten.
	function automatic void close_line();
		if (line_seen && (phase != PH_COMMENT))
			push_out(NEWLINE);
		phase         = PH_LEAD;
		line_seen     = 1'b0;
		blank_count   = '0;
		blank_dropped = 1'b0;
	endfunction

	// Works out the results that one text byte causes and leaves them in
	// step_out, the last one marked.
	function automatic void strip_byte(in_t it);
		logic [7:0] b;
		b = it.in_byte;
		step_out.delete();
		if (b == NEWLINE) begin
			close_line();
		end else begin
			line_seen = 1'b1;
			unique case (phase)
				PH_LEAD: begin
					if (b == HASH) begin
						phase = PH_COMMENT;
					end else if (!blank_char(b)) begin
						phase = PH_BODY;
						push_out(b);
					end
				end
				PH_BODY: begin
					if (blank_char(b)) begin
						// Inner whitespace waits for the next visible byte; once
						// the store is full further blanks are lost.
						if (blank_count < DEPTH) begin
							blank_codes[blank_count] = (b == SPACE) ? 3'd0 : 3'(b - 8'd8);
							blank_count++;
						end else begin
							blank_dropped = 1'b1;
						end
					end else begin
						for (int i = 0; i < blank_count; i++)
							push_out((blank_codes[i] == 3'd0) ? SPACE
								: 8'd8 + 8'(blank_codes[i]));
						blank_count = '0;
						push_out(b);
					end
				end
				default: ;  // Everything on a comment line is dropped.
			endcase
		end
		if (it.end_of_data)
			close_line();
		if (step_out.size() != 0)
			step_out[step_out.size() - 1].out_last = 1'b1;
	endfunction

	// Cycles to wait before the next item on one side. Now and then a side
	// enters a calm stretch in which it does not idle at all.
	function automatic int pick_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 11) == 0) begin
			calm = $urandom_range(4, 16);
			return 0;
		end
		return $urandom_range(0, 18);
	endfunction

	function automatic logic [7:0] pick_blank();
		logic [7:0] pool [5];
		pool = '{SPACE, TAB, VTAB, FEED, CRET};
		return pool[$urandom_range(0, 4)];
	endfunction

	function automatic logic [7:0] pick_glyph();
		logic [7:0] g;
		do
			g = 8'($urandom_range(0, 255));
		while (blank_char(g) || (g == NEWLINE));
		return g;
	endfunction

	// Offers one item after a random gap and returns at the edge that accepts
	// it. Valid stays high into the next item when that item has no gap.
	task automatic offer_item(in_t it);
		int gap;
		gap = pick_wait(in_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Receiver: stalls a random number of cycles, then holds ready high until
	// one result has been taken.
	initial begin : receiver
		int stall;
		do
			@(posedge clk);
		while (!arst_n);
		forever begin
			stall = pick_wait(out_calm);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!out_valid);
		end
	end

	// Every accepted result is compared with the oldest expected one.
	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (cleaned_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: extra result %h last %b ovf %b", $realtime,
						out_data.out_byte, out_data.out_last, out_data.ws_overflow);
			end else begin
				want = cleaned_due.pop_front();
				if ((out_data.out_byte !== want.out_byte)
					|| (out_data.out_last !== want.out_last)
					|| (out_data.ws_overflow !== want.ws_overflow)) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: got %h last %b ovf %b, expected %h last %b ovf %b",
							$realtime, out_data.out_byte, out_data.out_last,
							out_data.ws_overflow, want.out_byte, want.out_last,
							want.ws_overflow);
				end
			end
		end
	end

	// The watchdog ends a run in which no item moves on either side for too long.
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < HANG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : stimulus
		in_t  it;
		in_t  line [$];
		int   kind;
		int   words;
		int   run;
		int   sent;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: typed rows queue their own results, but every row
		// still goes through the predictor so that its line state stays current.
		for (int r = 0; r < $size(plan); r++) begin
			it = {plan[r].b, plan[r].eod};
			strip_byte(it);
			if (plan[r].typed) begin
				if (plan[r].n >= 2'd1)
					cleaned_due.push_back(plan[r].r0);
				if (plan[r].n == 2'd2)
					cleaned_due.push_back(plan[r].r1);
			end else begin
				foreach (step_out[k])
					cleaned_due.push_back(step_out[k]);
			end
			offer_item(it);
		end

		// Random part: about half of them well-formed lines with random content, some of
		// them with long inner whitespace runs that fill the pending store,
		// mixed with comment, blank and whitespace-only lines and raw noise.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			line.delete();
			kind = $urandom_range(0, 15);
			if (kind < 8) begin
				repeat ($urandom_range(0, 3))
					line.push_back({pick_blank(), 1'b0});
				words = $urandom_range(1, 4);
				for (int w = 0; w < words; w++) begin
					if (w > 0) begin
						run = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 20)
							: $urandom_range(1, 3);
						repeat (run)
							line.push_back({pick_blank(), 1'b0});
					end
					repeat ($urandom_range(1, 5))
						line.push_back({pick_glyph(), 1'b0});
				end
				repeat ($urandom_range(0, 3))
					line.push_back({pick_blank(), 1'b0});
			end else if (kind < 10) begin
				repeat ($urandom_range(0, 2))
					line.push_back({pick_blank(), 1'b0});
				line.push_back({HASH, 1'b0});
				repeat ($urandom_range(0, 6))
					line.push_back({($urandom_range(0, 1) != 0) ? pick_glyph() : pick_blank(),
						1'b0});
			end else if (kind < 13) begin
				// A whitespace-only line; with no bytes at all it stays empty.
				repeat ($urandom_range(0, 4))
					line.push_back({pick_blank(), 1'b0});
			end else begin
				repeat ($urandom_range(1, 8))
					line.push_back({8'($urandom_range(0, 255)),
						($urandom_range(0, 15) == 0)});
			end

			// Most lines end in a newline, some in end of data on their last byte.
			if ((line.size() != 0) && ($urandom_range(0, 7) == 0))
				line[line.size() - 1].end_of_data = 1'b1;
			else
				line.push_back({NEWLINE, ($urandom_range(0, 9) == 0)});

			foreach (line[k]) begin
				strip_byte(line[k]);
				foreach (step_out[j])
					cleaned_due.push_back(step_out[j]);
				offer_item(line[k]);
			end
			sent += line.size();
		end
		in_valid <= 1'b0;

		while (cleaned_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if ((mismatches == 0) && (cleaned_due.size() == 0))
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[files.f]
+incdir+hdl
hdl/cbls_pkg.sv
hdl/cbls_ram.sv
hdl/comment_blank_line_stripper_unit.sv
hdl/cbls_checker.sv
bench/tb_comment_blank_line_stripper_unit.sv
